FILE: hw/rtl/prq_pkg.sv
// Shared types, sizes and command codes of the priority run queue.
package prq_pkg;

    localparam int NUM_THREADS = 32;
    localparam int PRIO_LEVELS = 32;
    localparam int NUM_CPUS    = 8;
    localparam int TID_W       = 5;
    localparam int LVL_W       = 5;
    localparam int CPU_W       = 3;
    localparam int MASK_W      = 8;

    // Request codes.
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_EXTRACT = 2'd2;

    // Datapath operation codes.
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_INS_A     = 3'd2;
    localparam logic [2:0] OP_INS_B     = 3'd3;
    localparam logic [2:0] OP_UNLINK    = 3'd4;
    localparam logic [2:0] OP_SCAN_NEXT = 3'd5;
    localparam logic [2:0] OP_WALK_HEAD = 3'd6;
    localparam logic [2:0] OP_WALK_NEXT = 3'd7;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TID_W-1:0]  thread_id;
        logic [LVL_W-1:0]  priority_req;
        logic [MASK_W-1:0] thread_affinity;
        logic [MASK_W-1:0] task_affinity;
        logic [CPU_W-1:0]  cpu_id;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [TID_W-1:0] out_thread;
        logic             error;
    } t_out_item;

    typedef struct packed {
        logic [2:0] op;
        logic       set_found;
        logic       set_err;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       queued;
        logic       nonempty;
        logic       lvl_zero;
        logic       match;
        logic       at_tail;
        logic       cpu_bad;
    } t_dp_status;

endpackage

FILE: hw/rtl/prq_datapath.sv
// Linked tables, working registers and result register of the run queue.
module prq_datapath import prq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_check,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_result
);

    logic [NUM_THREADS-1:0] r_queued;
    logic [PRIO_LEVELS-1:0] r_nonempty;
    logic [LVL_W-1:0]  r_level [NUM_THREADS];
    logic [MASK_W-1:0] r_mask  [NUM_THREADS];
    logic [TID_W-1:0]  r_next  [NUM_THREADS];
    logic [TID_W-1:0]  r_prev  [NUM_THREADS];
    logic [TID_W-1:0]  r_head  [PRIO_LEVELS];
    logic [TID_W-1:0]  r_tail  [PRIO_LEVELS];

    logic [1:0]        r_req;
    logic [TID_W-1:0]  r_t;
    logic [LVL_W-1:0]  r_lv;
    logic [MASK_W-1:0] r_mask_in;
    logic [CPU_W-1:0]  r_cpu;
    logic              r_found;
    logic              r_err;
    t_out_item         r_out;

    logic [LVL_W-1:0] n_sat_lv;
    logic [LVL_W-1:0] u_lv;
    logic [TID_W-1:0] u_nx;
    logic [TID_W-1:0] u_pv;
    logic             u_head;
    logic             u_tail;

    // Saturate the requested level to the top level.
    assign n_sat_lv = (32'(i_item.priority_req) >= PRIO_LEVELS)
                      ? LVL_W'(PRIO_LEVELS - 1) : i_item.priority_req;

    // Neighbours of the thread being unlinked.
    assign u_lv   = r_level[r_t];
    assign u_nx   = r_next[r_t];
    assign u_pv   = r_prev[r_t];
    assign u_head = (r_head[u_lv] == r_t);
    assign u_tail = (r_tail[u_lv] == r_t);

    // Status for the controller.
    assign o_status.req      = r_req;
    assign o_status.queued   = r_queued[r_t];
    assign o_status.nonempty = r_nonempty[r_lv];
    assign o_status.lvl_zero = (r_lv == '0);
    assign o_status.match    = !i_check || r_mask[r_t][r_cpu];
    assign o_status.at_tail  = (r_tail[r_lv] == r_t);
    assign o_status.cpu_bad  = i_check && (32'(r_cpu) >= NUM_CPUS);
    assign o_result          = r_out;

    // Valid marks: cleared at reset, everything else is written before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued   <= '0;
            r_nonempty <= '0;
        end else begin
            case (i_cmd.op)
                OP_INS_B: begin
                    r_queued[r_t]    <= 1'b1;
                    r_nonempty[r_lv] <= 1'b1;
                end
                OP_UNLINK: begin
                    r_queued[r_t] <= 1'b0;
                    if (u_head && u_tail) begin
                        r_nonempty[u_lv] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Tables and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_req     <= i_item.req_type;
                r_t       <= i_item.thread_id;
                r_mask_in <= i_item.thread_affinity & i_item.task_affinity;
                r_cpu     <= i_item.cpu_id;
                r_lv      <= (i_item.req_type == REQ_EXTRACT)
                             ? LVL_W'(PRIO_LEVELS - 1) : n_sat_lv;
            end
            OP_INS_A: begin
                r_level[r_t] <= r_lv;
                r_mask[r_t]  <= r_mask_in;
                r_next[r_t]  <= r_t;
                r_prev[r_t]  <= r_nonempty[r_lv] ? r_tail[r_lv] : r_t;
            end
            OP_INS_B: begin
                if (r_nonempty[r_lv]) begin
                    r_next[r_tail[r_lv]] <= r_t;
                end else begin
                    r_head[r_lv] <= r_t;
                end
                r_tail[r_lv] <= r_t;
            end
            OP_UNLINK: begin
                if (u_head && !u_tail) begin
                    r_head[u_lv] <= u_nx;
                end else if (u_tail && !u_head) begin
                    r_tail[u_lv] <= u_pv;
                end else if (!u_head && !u_tail) begin
                    r_next[u_pv] <= u_nx;
                    r_prev[u_nx] <= u_pv;
                end
            end
            OP_SCAN_NEXT: r_lv <= r_lv - 1'b1;
            OP_WALK_HEAD: r_t  <= r_head[r_lv];
            OP_WALK_NEXT: r_t  <= r_next[r_t];
            default: begin
            end
        endcase
    end

    // Result flags and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_found <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out.found      <= r_found;
            r_out.out_thread <= r_found ? r_t : '0;
            r_out.error      <= r_err;
        end
    end

endmodule

FILE: hw/rtl/prq_ctrl.sv
// Sequencing state machine of the run queue and the output valid flag.
module prq_ctrl import prq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_INSA = 3'd2;
    localparam logic [2:0] S_INSB = 3'd3;
    localparam logic [2:0] S_UNL  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_WALK = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                case (i_status.req)
                    REQ_INSERT: begin
                        if (i_status.queued) begin
                            o_cmd.set_err = 1'b1;
                            n_state       = S_FIN;
                        end else begin
                            n_state = S_INSA;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!i_status.queued) begin
                            o_cmd.set_err = 1'b1;
                            n_state       = S_FIN;
                        end else begin
                            n_state = S_UNL;
                        end
                    end
                    REQ_EXTRACT: n_state = i_status.cpu_bad ? S_FIN : S_SCAN;
                    default:     n_state = S_FIN;
                endcase
            end
            S_INSA: begin
                o_cmd.op = OP_INS_A;
                n_state  = S_INSB;
            end
            S_INSB: begin
                o_cmd.op = OP_INS_B;
                n_state  = S_FIN;
            end
            S_UNL: begin
                o_cmd.op = OP_UNLINK;
                n_state  = S_FIN;
            end
            S_SCAN: begin
                if (i_status.nonempty) begin
                    o_cmd.op = OP_WALK_HEAD;
                    n_state  = S_WALK;
                end else if (i_status.lvl_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                end
            end
            S_WALK: begin
                if (i_status.match) begin
                    o_cmd.op        = OP_UNLINK;
                    o_cmd.set_found = 1'b1;
                    n_state         = S_FIN;
                end else if (!i_status.at_tail) begin
                    o_cmd.op = OP_WALK_NEXT;
                end else if (i_status.lvl_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = S_SCAN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output beat stays valid until it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/priority_run_queue_affinity_unit.sv
// Top level of the multilevel priority run queue with CPU affinity.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (affinity enable)
//
// One request is handled at a time; each gives exactly one result beat.
// Insert runs decode, insert A, insert B and final; remove runs decode,
// unlink and final; a rejected or unused request decode and final. Extract
// runs decode, a one-level-per-cycle scan, a one-link-per-cycle walk, final.
// Reset clears the queued and non-empty marks at once; no clearing pass.
// A stalled output beat holds the block in its final state until taken.
module priority_run_queue_affinity_unit import prq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    logic       r_aff_en;
    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration register, always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aff_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_aff_en <= i_cfg_data;
        end
    end

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    prq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_check  (r_aff_en),
        .i_item   (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_out_data)
    );

`ifndef ASSERT_OFF
    // A returned thread is never also flagged as an error.
    a_found_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.found && o_out_data.error))
        else $error("found and error both set");

    // One request at a time: no new beat right after one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    // A result beat is produced only after a request has been taken.
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without request");
`endif

endmodule
